// ===== src/ucbmls_pkg.sv =====
package ucbmls_pkg;

  localparam logic [15:0] MIN_COMMITS_RST = 16'd30;
  localparam logic [31:0] LOG10_2_Q32     = 32'd1292913986;
  localparam logic [31:0] U32_MAX         = 32'hFFFF_FFFF;
  localparam logic [47:0] SUM_MAX         = 48'hFFFF_FFFF_FFFF;
  localparam logic [5:0]  LOG_STEPS       = 6'd24;
  localparam logic [5:0]  DIV_STEPS       = 6'd32;
  localparam logic [5:0]  SQRT_STEPS      = 6'd28;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_DRAIN_ROT   = 3'd1,
    ACT_ENABLE_ROT  = 3'd2,
    ACT_ROT_NO_HTM  = 3'd3,
    ACT_DISABLE_HTM = 3'd4
  } mode_action_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_UPDATE,
    OP_LOG_LOAD,
    OP_NORM,
    OP_SQ_MUL,
    OP_SQ_NRM,
    OP_LOG10,
    OP_SCORE_INIT,
    OP_DEN_MUL,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_COMPARE,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    EMIT_SKIP,
    EMIT_NEXT,
    EMIT_PICK
  } emit_kind_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_UPD,
    S_LOG_LOAD,
    S_NORM,
    S_SQ_MUL,
    S_SQ_NRM,
    S_LOG10,
    S_SCORE_INIT,
    S_DEN_MUL,
    S_DIV_LOAD,
    S_DIV,
    S_SQRT_LOAD,
    S_SQRT,
    S_COMPARE,
    S_EMIT_SKIP,
    S_EMIT_NEXT,
    S_EMIT_PICK
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    emit_kind_e emit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic need_pick;
    logic norm_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/ucbmls_in_if.sv =====
interface ucbmls_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_commits;

  modport source (output valid, output sample_commits, input ready);
  modport sink (input valid, input sample_commits, output ready);
endinterface

// ===== src/ucbmls_out_if.sv =====
interface ucbmls_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lever;
  logic       lever_changed;
  logic [2:0] mode_action;
  logic       double_period;
  logic       sample_used;

  modport source (
    output valid, output lever, output lever_changed, output mode_action,
    output double_period, output sample_used, input ready
  );
  modport sink (
    input valid, input lever, input lever_changed, input mode_action,
    input double_period, input sample_used, output ready
  );
endinterface

// ===== src/ucb_mode_lever_selector_unit.sv =====
// UCB mode-lever selector: one commit count in, one lever decision out.
// Input channel in_ch carries sample_commits, one beat per sampling period.
// Output channel out_ch carries lever, lever_changed, mode_action,
// double_period and sample_used, exactly one beat per input beat.
// The user must write min_commits through cfg_we_i / cfg_wdata_i only while
// idle; the block itself does not enforce this. A zero or below-threshold
// sample, and an exploration step, are emitted without scoring. A scored step
// runs the log2 squaring loop and, per lever, the 32-step serial divider
// followed by the 28-step square-root iteration.
// One item is in work at a time; in_ch.ready is high only while idle.
// The result sits in an output register, so a new sample is taken while the
// receiver stalls; a finished decision waits there until out_ch.ready.
// Reset restores min_commits to 30, lever 0, exploration on, rot enabled
// and clears all statistics.
module ucb_mode_lever_selector_unit #(
  parameter int NUM_LEVERS = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ucbmls_in_if.sink    in_ch,
  ucbmls_out_if.source out_ch,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);
  import ucbmls_pkg::*;

  localparam int LW = $clog2(NUM_LEVERS);

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [LW-1:0] sel;

  ucbmls_ctrl #(.NUM_LEVERS(NUM_LEVERS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .sel_o      (sel)
  );

  ucbmls_dp #(.NUM_LEVERS(NUM_LEVERS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_i        (in_ch.sample_commits),
    .cmd_i           (cmd),
    .sel_i           (sel),
    .status_o        (status),
    .out_ready_i     (out_ch.ready),
    .out_valid_o     (out_ch.valid),
    .lever_o         (out_ch.lever),
    .lever_changed_o (out_ch.lever_changed),
    .mode_action_o   (out_ch.mode_action),
    .double_period_o (out_ch.double_period),
    .sample_used_o   (out_ch.sample_used)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted a sample while one is in work");

  a_action_needs_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.mode_action != ACT_NONE |-> out_ch.lever_changed)
    else $error("mode action without a lever change");

  a_skip_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.sample_used |->
      !out_ch.lever_changed && out_ch.mode_action == ACT_NONE)
    else $error("unused sample changed the lever");

  a_double_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.double_period |-> !out_ch.sample_used)
    else $error("doubled period on a used sample");
`endif

endmodule

// ===== src/ucbmls_ctrl.sv =====
module ucbmls_ctrl #(
  parameter int NUM_LEVERS = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ucbmls_pkg::dp_status_t           status_i,
  output ucbmls_pkg::dp_cmd_t              cmd_o,
  output logic [$clog2(NUM_LEVERS)-1:0]    sel_o
);
  import ucbmls_pkg::*;

  localparam int LW = $clog2(NUM_LEVERS);

  ctrl_state_e   state_q, state_d;
  logic [5:0]    cnt_q;
  logic [LW-1:0] lev_q;
  logic          last_lev;

  assign last_lev = (lev_q == LW'(NUM_LEVERS - 1));
  assign sel_o    = lev_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:       if (in_valid_i) state_d = S_UPD;
      S_UPD: begin
        if (status_i.skip) state_d = S_EMIT_SKIP;
        else if (status_i.need_pick) state_d = S_LOG_LOAD;
        else state_d = S_EMIT_NEXT;
      end
      S_LOG_LOAD:   state_d = S_NORM;
      S_NORM:       if (status_i.norm_done) state_d = S_SQ_MUL;
      S_SQ_MUL:     state_d = S_SQ_NRM;
      S_SQ_NRM:     state_d = (cnt_q == LOG_STEPS - 6'd1) ? S_LOG10 : S_SQ_MUL;
      S_LOG10:      state_d = S_SCORE_INIT;
      S_SCORE_INIT: state_d = S_DEN_MUL;
      S_DEN_MUL:    state_d = S_DIV_LOAD;
      S_DIV_LOAD:   state_d = S_DIV;
      S_DIV:        if (cnt_q == DIV_STEPS - 6'd1) state_d = S_SQRT_LOAD;
      S_SQRT_LOAD:  state_d = S_SQRT;
      S_SQRT:       if (cnt_q == SQRT_STEPS - 6'd1) state_d = S_COMPARE;
      S_COMPARE:    state_d = last_lev ? S_EMIT_PICK : S_DEN_MUL;
      S_EMIT_SKIP,
      S_EMIT_NEXT,
      S_EMIT_PICK:  if (status_i.out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.emit  = EMIT_SKIP;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LATCH;
      end
      S_UPD:        if (!status_i.skip) cmd_o.op = OP_UPDATE;
      S_LOG_LOAD:   cmd_o.op = OP_LOG_LOAD;
      S_NORM:       cmd_o.op = OP_NORM;
      S_SQ_MUL:     cmd_o.op = OP_SQ_MUL;
      S_SQ_NRM:     cmd_o.op = OP_SQ_NRM;
      S_LOG10:      cmd_o.op = OP_LOG10;
      S_SCORE_INIT: cmd_o.op = OP_SCORE_INIT;
      S_DEN_MUL:    cmd_o.op = OP_DEN_MUL;
      S_DIV_LOAD:   cmd_o.op = OP_DIV_LOAD;
      S_DIV:        cmd_o.op = OP_DIV_STEP;
      S_SQRT_LOAD:  cmd_o.op = OP_SQRT_LOAD;
      S_SQRT:       cmd_o.op = OP_SQRT_STEP;
      S_COMPARE:    cmd_o.op = OP_COMPARE;
      S_EMIT_SKIP: begin
        cmd_o.emit = EMIT_SKIP;
        if (status_i.out_free) cmd_o.op = OP_EMIT;
      end
      S_EMIT_NEXT: begin
        cmd_o.emit = EMIT_NEXT;
        if (status_i.out_free) cmd_o.op = OP_EMIT;
      end
      S_EMIT_PICK: begin
        cmd_o.emit = EMIT_PICK;
        if (status_i.out_free) cmd_o.op = OP_EMIT;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      lev_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_NORM || state_q == S_DIV_LOAD || state_q == S_SQRT_LOAD) begin
        cnt_q <= '0;
      end else if (state_q == S_SQ_NRM || state_q == S_DIV || state_q == S_SQRT) begin
        cnt_q <= cnt_q + 6'd1;
      end
      if (state_q == S_SCORE_INIT) begin
        lev_q <= '0;
      end else if (state_q == S_COMPARE && !last_lev) begin
        lev_q <= lev_q + LW'(1);
      end
    end
  end

endmodule

// ===== src/ucbmls_dp.sv =====
module ucbmls_dp #(
  parameter int NUM_LEVERS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic [31:0]                   sample_i,
  input  ucbmls_pkg::dp_cmd_t           cmd_i,
  input  logic [$clog2(NUM_LEVERS)-1:0] sel_i,
  output ucbmls_pkg::dp_status_t        status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    lever_o,
  output logic                          lever_changed_o,
  output logic [2:0]                    mode_action_o,
  output logic                          double_period_o,
  output logic                          sample_used_o
);
  import ucbmls_pkg::*;

  localparam int LW = $clog2(NUM_LEVERS);

  // bandit state
  logic [15:0]   min_commits_q;
  logic [LW-1:0] cur_q;
  logic          exploring_q;
  logic          rot_q;
  logic [31:0]   best_count_q;
  logic [31:0]   total_q;
  logic [31:0]   trials_q [NUM_LEVERS];
  logic [47:0]   sum_q    [NUM_LEVERS];

  logic [31:0]   sample_q;

  // log unit
  logic [31:0]   y_q;
  logic [4:0]    n_q;
  logic [23:0]   frac_q;
  logic [63:0]   prod_q;
  logic [31:0]   l2x_q;

  // score unit
  logic [63:0]   den_q;
  logic [31:0]   trl_q;
  logic [47:0]   num_q;
  logic [71:0]   x_q, t_q;
  logic          xsat_q;
  logic [31:0]   eq_q;
  logic [32:0]   arem_q;
  logic [31:0]   adq_q;
  logic [55:0]   sv_q, sres_q, sbit_q;
  logic [31:0]   best_s_q;
  logic [LW-1:0] pick_q;

  // result register
  logic          out_valid_q;
  logic [1:0]    lever_q;
  logic          changed_q;
  logic [2:0]    action_q;
  logic          dbl_q;
  logic          used_q;

  logic          is_zero, is_below, out_free;
  logic [LW-1:0] rd_idx;
  logic [31:0]   trl_rd;
  logic [47:0]   sum_rd;
  logic [48:0]   sum_add;
  logic [32:0]   sq_top;
  logic [32:0]   arem_sh;
  logic          a_bit;
  logic          x_ge;
  logic [55:0]   s_try;
  logic [31:0]   exploit;
  logic [32:0]   score_raw;
  logic [31:0]   score;
  logic [LW-1:0] new_lever;
  logic          changed;
  mode_action_e  action;
  logic          rot_d;

  assign is_zero  = (sample_q == '0);
  assign is_below = (sample_q < {16'd0, min_commits_q});
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.skip      = is_zero || is_below;
  assign status_o.need_pick = !exploring_q ||
                              (({1'b0, cur_q} + (LW+1)'(1)) >= (LW+1)'(NUM_LEVERS));
  assign status_o.norm_done = y_q[31];
  assign status_o.out_free  = out_free;

  assign rd_idx  = (cmd_i.op == OP_UPDATE) ? cur_q : sel_i;
  assign trl_rd  = trials_q[rd_idx];
  assign sum_rd  = sum_q[rd_idx];
  assign sum_add = {1'b0, sum_rd} + {17'd0, sample_q};

  assign sq_top  = prod_q[63:31];
  assign arem_sh = {arem_q[31:0], adq_q[31]};
  assign a_bit   = (arem_sh >= {1'b0, trl_q});
  assign x_ge    = (x_q >= t_q);
  assign s_try   = sres_q + sbit_q;

  assign exploit   = xsat_q ? U32_MAX : eq_q;
  assign score_raw = {1'b0, exploit} + {1'b0, sres_q[31:0]};
  assign score     = score_raw[32] ? U32_MAX : score_raw[31:0];

  always_comb begin
    unique case (cmd_i.emit)
      EMIT_NEXT: new_lever = cur_q + LW'(1);
      EMIT_PICK: new_lever = pick_q;
      default:   new_lever = cur_q;
    endcase
  end

  // mode switch required by a change of lever
  always_comb begin
    changed = (cmd_i.emit != EMIT_SKIP) && (new_lever != cur_q);
    action  = ACT_NONE;
    rot_d   = rot_q;
    if (changed) begin
      priority if (new_lever == LW'(1)) begin
        if (rot_q) begin
          action = ACT_DRAIN_ROT;
          rot_d  = 1'b0;
        end
      end else if (new_lever == '0) begin
        if (!rot_q) begin
          action = ACT_ENABLE_ROT;
          rot_d  = 1'b1;
        end
      end else if (cur_q != '0) begin
        action = ACT_ROT_NO_HTM;
        rot_d  = 1'b1;
      end else begin
        action = ACT_DISABLE_HTM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_commits_q <= MIN_COMMITS_RST;
      cur_q         <= '0;
      exploring_q   <= 1'b1;
      rot_q         <= 1'b1;
      best_count_q  <= '0;
      total_q       <= '0;
      for (int i = 0; i < NUM_LEVERS; i++) begin
        trials_q[i] <= '0;
        sum_q[i]    <= '0;
      end
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) min_commits_q <= cfg_wdata_i;
      if (cmd_i.op == OP_UPDATE) begin
        if (sample_q > best_count_q) best_count_q <= sample_q;
        if (total_q != U32_MAX) total_q <= total_q + 32'd1;
        if (trl_rd != U32_MAX) trials_q[cur_q] <= trl_rd + 32'd1;
        sum_q[cur_q] <= sum_add[48] ? SUM_MAX : sum_add[47:0];
        if (status_o.need_pick) exploring_q <= 1'b0;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
        cur_q       <= new_lever;
        rot_q       <= rot_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: sample_q <= sample_i;
      OP_LOG_LOAD: begin
        y_q    <= total_q;
        n_q    <= 5'd31;
        frac_q <= '0;
      end
      OP_NORM: begin
        if (!y_q[31]) begin
          y_q <= {y_q[30:0], 1'b0};
          n_q <= n_q - 5'd1;
        end
      end
      OP_SQ_MUL: prod_q <= {32'd0, y_q} * {32'd0, y_q};
      OP_SQ_NRM: begin
        // square is in [1,4): a carry into bit 32 yields the next log bit
        frac_q <= {frac_q[22:0], sq_top[32]};
        y_q    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
      end
      OP_LOG10: prod_q <= {32'd0, 3'd0, n_q, frac_q} * {32'd0, LOG10_2_Q32};
      OP_SCORE_INIT: begin
        l2x_q    <= {prod_q[62:32], 1'b0};
        best_s_q <= '0;
        pick_q   <= '0;
      end
      OP_DEN_MUL: begin
        den_q <= {32'd0, best_count_q} * {32'd0, trl_rd};
        trl_q <= trl_rd;
        num_q <= sum_rd;
      end
      OP_DIV_LOAD: begin
        x_q    <= {24'd0, num_q};
        t_q    <= {1'b0, den_q, 7'd0};
        xsat_q <= ({24'd0, num_q} >= {den_q, 8'd0});
        eq_q   <= '0;
        arem_q <= '0;
        adq_q  <= l2x_q;
      end
      OP_DIV_STEP: begin
        // exploit ratio: one quotient bit per beat, weights 2^7 down to 2^-24
        x_q    <= x_ge ? {x_q[70:0] - t_q[70:0], 1'b0} : {x_q[70:0], 1'b0};
        eq_q   <= {eq_q[30:0], x_ge};
        arem_q <= a_bit ? (arem_sh - {1'b0, trl_q}) : arem_sh;
        adq_q  <= {adq_q[30:0], a_bit};
      end
      OP_SQRT_LOAD: begin
        sv_q   <= {adq_q, 24'd0};
        sres_q <= '0;
        sbit_q <= 56'd1 << 54;
      end
      OP_SQRT_STEP: begin
        if (sv_q >= s_try) begin
          sv_q   <= sv_q - s_try;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      OP_COMPARE: begin
        if (trl_q != '0 && score > best_s_q) begin
          best_s_q <= score;
          pick_q   <= sel_i;
        end
      end
      OP_EMIT: begin
        lever_q   <= 2'(new_lever);
        changed_q <= changed;
        action_q  <= action;
        dbl_q     <= (cmd_i.emit == EMIT_SKIP) && !is_zero && is_below;
        used_q    <= (cmd_i.emit != EMIT_SKIP);
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign lever_o         = lever_q;
  assign lever_changed_o = changed_q;
  assign mode_action_o   = action_q;
  assign double_period_o = dbl_q;
  assign sample_used_o   = used_q;

endmodule
